### rtl/mwsl_pkg.sv
// ----------------------------------------------------------------------------
// mwsl_pkg - shared definitions of the mecanum wheel speed limiter
// Fixed-point widths, constants, microcode control word and its program ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsl_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BASE_SUM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WHEEL_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WHEEL_SPEED  = 2'd2;

    localparam logic [15:0] HBS_RESET = 16'd16384;
    localparam logic [15:0] INV_RESET = 16'd5120;
    localparam logic [14:0] LIM_RESET = 15'd300;

    // stream payload widths
    localparam int IN_FIELD_W  = 16;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 72;
    localparam int SPEED_W     = 16;
    localparam int STEPS_W     = 5;

    localparam int MAX_RETRIES = 30;

    // datapath widths
    localparam int V_W    = 30;   // velocity vector, Q.8
    localparam int SUM_W  = 32;   // vx +/- vy +/- kw
    localparam int W_W    = 20;   // unsaturated wheel speed
    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;
    localparam int RND_W  = 30;   // rounded magnitude

    // rounding shifts per operation kind
    localparam int SH_K = 16;
    localparam int SH_W = 28;
    localparam int SH_V = 30;

    localparam logic signed [MUL_W-1:0] SCALE_ONE  = 32'sd1073741824;
    localparam logic signed [MUL_W-1:0] SCALE_STEP = 32'sd35791466;

    // sequencer
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_WAIT = 5'd0;
    localparam logic [STEP_W-1:0] ST_LOOP = 5'd1;
    localparam logic [STEP_W-1:0] ST_EMIT = 5'd21;

    typedef enum logic [2:0] {
        SQ_NEXT,
        SQ_WAIT_IN,
        SQ_BRANCH,
        SQ_JUMP,
        SQ_EMIT
    } seq_op_t;

    typedef enum logic [2:0] {
        A_V0,
        A_V1,
        A_V2,
        A_S0,
        A_S1,
        A_S2,
        A_S3
    } a_sel_t;

    typedef enum logic [1:0] {
        B_K,
        B_INV,
        B_SCL
    } b_sel_t;

    typedef enum logic [2:0] {
        D_V0,
        D_V1,
        D_V2,
        D_KW,
        D_W0,
        D_W1,
        D_W2,
        D_W3
    } dest_t;

    typedef struct packed {
        seq_op_t           seq;
        logic [STEP_W-1:0] target;
        logic              issue;
        a_sel_t            a_sel;
        b_sel_t            b_sel;
        dest_t             dest;
        logic              sums;
    } ctrl_t;

    localparam ctrl_t UC_NOP = '{
        seq: SQ_NEXT, target: ST_WAIT, issue: 1'b0,
        a_sel: A_V0, b_sel: B_K, dest: D_V0, sums: 1'b0
    };

    // Program: wait for input, then one pass of yaw term, sums, four wheel products and limit branch,
    // then the rescale of the vector and a jump back to the pass; the branch exits to the emit step.
    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = UC_NOP;
        case (step)
            5'd0:
            begin
                c.seq = SQ_WAIT_IN;
            end
            5'd1:
            begin
                c.issue = 1'b1; c.a_sel = A_V2; c.b_sel = B_K; c.dest = D_KW;
            end
            5'd5:
            begin
                c.sums = 1'b1;
            end
            5'd6:
            begin
                c.issue = 1'b1; c.a_sel = A_S0; c.b_sel = B_INV; c.dest = D_W0;
            end
            5'd7:
            begin
                c.issue = 1'b1; c.a_sel = A_S1; c.b_sel = B_INV; c.dest = D_W1;
            end
            5'd8:
            begin
                c.issue = 1'b1; c.a_sel = A_S2; c.b_sel = B_INV; c.dest = D_W2;
            end
            5'd9:
            begin
                c.issue = 1'b1; c.a_sel = A_S3; c.b_sel = B_INV; c.dest = D_W3;
            end
            5'd13:
            begin
                c.seq = SQ_BRANCH; c.target = ST_EMIT;
            end
            5'd14:
            begin
                c.issue = 1'b1; c.a_sel = A_V0; c.b_sel = B_SCL; c.dest = D_V0;
            end
            5'd15:
            begin
                c.issue = 1'b1; c.a_sel = A_V1; c.b_sel = B_SCL; c.dest = D_V1;
            end
            5'd16:
            begin
                c.issue = 1'b1; c.a_sel = A_V2; c.b_sel = B_SCL; c.dest = D_V2;
            end
            5'd20:
            begin
                c.seq = SQ_JUMP; c.target = ST_LOOP;
            end
            5'd21:
            begin
                c.seq = SQ_EMIT; c.target = ST_WAIT;
            end
            default:
            begin
                c = UC_NOP;
            end
        endcase
        return c;
    endfunction

    // input * 60 << 8 = (x << 14) - (x << 10)
    function automatic logic signed [V_W-1:0] load_vel(input logic [IN_FIELD_W-1:0] x);
        logic signed [V_W-1:0] xe;
        xe = V_W'($signed(x));
        return (xe <<< 14) - (xe <<< 10);
    endfunction

    function automatic logic [SPEED_W-1:0] sat16(input logic signed [W_W-1:0] w);
        logic [SPEED_W-1:0] r;
        if (w > $signed(W_W'(32767)))
            r = 16'h7FFF;
        else if (w < -$signed(W_W'(32768)))
            r = 16'h8000;
        else
            r = w[SPEED_W-1:0];
        return r;
    endfunction

    function automatic logic signed [MUL_W-1:0] scale_of(input logic [STEPS_W-1:0] n);
        return SCALE_ONE - $signed({{(MUL_W-STEPS_W){1'b0}}, n}) * SCALE_STEP;
    endfunction

endpackage

`default_nettype wire

### rtl/mecanum_wheel_speed_limiter.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_limiter - mecanum inverse kinematics with speed limit
// Microcoded sequencer around one shared signed multiply-and-round pipeline.
// ----------------------------------------------------------------------------
// A command runs one program pass and one more per retry, n = scale_steps; the
//   next command is taken only after its result is emitted, since each 20-step
//   program pass reuses the single 32x32 multiplier pipeline.
// The next input is taken while a finished result still waits in the output reg.
// Reset: asynchronous, active low; configuration and control registers return to
//   their defaults, the sequencer to its wait step and the output goes invalid.
`default_nettype none

module mecanum_wheel_speed_limiter (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [mwsl_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [mwsl_pkg::CFG_DATA_W-1:0]    cfg_data,
    // body velocity command
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: vel_forward[15:0], vel_side[31:16], yaw_rate[47:32]
    input  logic [mwsl_pkg::S_DATA_W-1:0]      s_tdata,
    // wheel speeds
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: speed_front_right[15:0], speed_front_left[31:16],
    //          speed_back_left[47:32], speed_back_right[63:48],
    //          scale_steps[68:64], zero pad[71:69]
    output logic [mwsl_pkg::M_DATA_W-1:0]      m_tdata
);
    import mwsl_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] hbs_reg;
    logic [15:0] inv_reg;
    logic [14:0] lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hbs_reg <= HBS_RESET;
            inv_reg <= INV_RESET;
            lim_reg <= LIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_HALF_BASE_SUM:    hbs_reg <= cfg_data;
                CFG_INV_WHEEL_RADIUS: inv_reg <= cfg_data;
                CFG_MAX_WHEEL_SPEED:  lim_reg <= cfg_data[14:0];
                default:              ; // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath state
    // ------------------------------------------------------------------
    logic signed [V_W-1:0]   v_reg [3];
    logic signed [V_W-1:0]   kw_reg;
    logic signed [SUM_W-1:0] sum_reg [4];
    logic signed [W_W-1:0]   w_reg [4];
    logic [STEPS_W-1:0]      n_reg, n_next;
    logic signed [MUL_W-1:0] s_reg, s_next;

    // sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    ctrl_t             ctrl;
    logic              load_in;
    logic              advance_scale;
    logic              emit;
    logic              limit_ok;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]  spd_reg [4];
    logic [STEPS_W-1:0]  steps_reg;

    // multiply-and-round pipeline
    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0]        mag_reg;
    logic [PROD_W-1:0]        half;
    logic [PROD_W-1:0]        rsum;
    logic [RND_W-1:0]         rnd;
    logic [RND_W-1:0]         rnd_reg;
    logic                     neg2_reg, neg3_reg;
    logic                     vld1_reg, vld2_reg, vld3_reg;
    dest_t                    dest1_reg, dest2_reg, dest3_reg;
    logic signed [RND_W:0]    wb_val;

    // ------------------------------------------------------------------
    // Limit check on the unsaturated speeds of the current pass
    // ------------------------------------------------------------------
    logic signed [W_W-1:0] lim_s;

    always_comb
    begin
        lim_s    = $signed({{(W_W-15){1'b0}}, lim_reg});
        limit_ok = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (w_reg[i] > lim_s || w_reg[i] < -lim_s)
                limit_ok = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: fetch the control word of the current step, resolve jumps
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl          = ucode_rom(step_reg);
        step_next     = step_reg + STEP_W'(1);
        s_tready      = 1'b0;
        load_in       = 1'b0;
        advance_scale = 1'b0;
        emit          = 1'b0;
        case (ctrl.seq)
            SQ_WAIT_IN:
            begin
                // hold on this step until a command transaction arrives
                s_tready = 1'b1;
                load_in  = s_tvalid;
                if (!s_tvalid)
                    step_next = step_reg;
            end
            SQ_BRANCH:
            begin
                // within limits or out of retries: emit; else shrink the vector
                if (limit_ok || n_reg >= STEPS_W'(MAX_RETRIES))
                    step_next = ctrl.target;
                else
                    advance_scale = 1'b1;
            end
            SQ_JUMP:
            begin
                step_next = ctrl.target;
            end
            SQ_EMIT:
            begin
                // wait until the output register is free or being drained
                if (!out_valid_reg || m_tready)
                begin
                    emit      = 1'b1;
                    step_next = ctrl.target;
                end
                else
                begin
                    step_next = step_reg;
                end
            end
            default:
            begin
                step_next = step_reg + STEP_W'(1);
            end
        endcase
    end

    always_comb
    begin
        n_next = n_reg;
        s_next = s_reg;
        if (load_in)
        begin
            n_next = '0;
            s_next = SCALE_ONE;
        end
        else if (advance_scale)
        begin
            // factor of the next retry: 1 - n * step, cumulative on the vector
            n_next = n_reg + STEPS_W'(1);
            s_next = s_reg - SCALE_STEP;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_WAIT;
            n_reg         <= '0;
            s_reg         <= SCALE_ONE;
            out_valid_reg <= 1'b0;
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            vld3_reg      <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            n_reg         <= n_next;
            s_reg         <= s_next;
            out_valid_reg <= out_valid_next;
            vld1_reg      <= ctrl.issue;
            vld2_reg      <= vld1_reg;
            vld3_reg      <= vld2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: operand select, product, magnitude, rounding
    // ------------------------------------------------------------------
    always_comb
    begin
        case (ctrl.a_sel)
            A_V0:    op_a = MUL_W'(v_reg[0]);
            A_V1:    op_a = MUL_W'(v_reg[1]);
            A_V2:    op_a = MUL_W'(v_reg[2]);
            A_S0:    op_a = sum_reg[0];
            A_S1:    op_a = sum_reg[1];
            A_S2:    op_a = sum_reg[2];
            A_S3:    op_a = sum_reg[3];
            default: op_a = '0;
        endcase
        case (ctrl.b_sel)
            B_K:     op_b = $signed({{(MUL_W-16){1'b0}}, hbs_reg});
            B_INV:   op_b = $signed({{(MUL_W-16){1'b0}}, inv_reg});
            B_SCL:   op_b = s_reg;
            default: op_b = '0;
        endcase
        prod_full = op_a * op_b;
    end

    // rounding shift follows from the destination: yaw term, wheel or rescale
    always_comb
    begin
        case (dest2_reg)
            D_KW:                    half = PROD_W'(1) << (SH_K - 1);
            D_W0, D_W1, D_W2, D_W3:  half = PROD_W'(1) << (SH_W - 1);
            default:                 half = PROD_W'(1) << (SH_V - 1);
        endcase
        rsum = mag_reg + half;
        case (dest2_reg)
            D_KW:                    rnd = rsum[SH_K+RND_W-1:SH_K];
            D_W0, D_W1, D_W2, D_W3:  rnd = rsum[SH_W+RND_W-1:SH_W];
            default:                 rnd = rsum[SH_V+RND_W-1:SH_V];
        endcase
        // ties went away from zero on the magnitude; restore the sign
        wb_val = neg3_reg ? -$signed({1'b0, rnd_reg}) : $signed({1'b0, rnd_reg});
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_full;
        dest1_reg <= ctrl.dest;
        mag_reg   <= prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        neg2_reg  <= prod_reg[PROD_W-1];
        dest2_reg <= dest1_reg;
        rnd_reg   <= rnd;
        neg3_reg  <= neg2_reg;
        dest3_reg <= dest2_reg;
    end

    // ------------------------------------------------------------------
    // Vector load, write-back and wheel sums
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            v_reg[0] <= load_vel(s_tdata[15:0]);
            v_reg[1] <= load_vel(s_tdata[31:16]);
            v_reg[2] <= load_vel(s_tdata[47:32]);
        end
        else if (vld3_reg)
        begin
            case (dest3_reg)
                D_V0:    v_reg[0] <= wb_val[V_W-1:0];
                D_V1:    v_reg[1] <= wb_val[V_W-1:0];
                D_V2:    v_reg[2] <= wb_val[V_W-1:0];
                D_KW:    kw_reg   <= wb_val[V_W-1:0];
                D_W0:    w_reg[0] <= wb_val[W_W-1:0];
                D_W1:    w_reg[1] <= wb_val[W_W-1:0];
                D_W2:    w_reg[2] <= wb_val[W_W-1:0];
                D_W3:    w_reg[3] <= wb_val[W_W-1:0];
                default: ;
            endcase
        end

        if (ctrl.sums)
        begin
            // front right, front left, back left, back right
            sum_reg[0] <= SUM_W'(v_reg[0]) + SUM_W'(v_reg[1]) + SUM_W'(kw_reg);
            sum_reg[1] <= SUM_W'(v_reg[0]) - SUM_W'(v_reg[1]) - SUM_W'(kw_reg);
            sum_reg[2] <= SUM_W'(v_reg[0]) + SUM_W'(v_reg[1]) - SUM_W'(kw_reg);
            sum_reg[3] <= SUM_W'(v_reg[0]) - SUM_W'(v_reg[1]) + SUM_W'(kw_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output register: saturate and hold until the transaction completes
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            for (int i = 0; i < 4; i++)
                spd_reg[i] <= sat16(w_reg[i]);
            steps_reg <= n_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-4*SPEED_W-STEPS_W){1'b0}}, steps_reg,
                       spd_reg[3], spd_reg[2], spd_reg[1], spd_reg[0]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_start_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (step_reg == ST_LOOP))
        else $error("command transaction did not start a pass");

    a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= STEPS_W'(MAX_RETRIES))
        else $error("retry count beyond limit");

    a_scale_track: assert property (@(posedge clk) disable iff (!rst_n)
        s_reg == scale_of(n_reg))
        else $error("scale factor out of step with retry count");

    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(step_reg) == ST_EMIT))
        else $error("result raised outside the emit step");

endmodule

`default_nettype wire
